FILE: design/sfct_pkg.sv
// Shared types, constants, saturating add and the sequencer control store.
`timescale 1ns / 1ps
package sfct_pkg;

  // Score codes in signed Q16.16.
  localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0001;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_OFFER   = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ    = 2'd3
  } req_type_t;

  // One input item.
  typedef struct packed {
    req_type_t          req_type;
    logic [4:0]         span_start;
    logic [4:0]         span_end;
    logic signed [31:0] offer_score;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] span_score;
    logic               span_covered;
  } out_item_t;

  // Sequencer steps.
  typedef enum logic [3:0] {
    U_CLR      = 4'd0,
    U_IDLE     = 4'd1,
    U_OF_RD    = 4'd2,
    U_OF_WR    = 4'd3,
    U_RD_RD    = 4'd4,
    U_RD_OUT   = 4'd5,
    U_CP_INIT  = 4'd6,
    U_CP_CELL  = 4'd7,
    U_CP_LEFT0 = 4'd8,
    U_CP_RIGHT = 4'd9,
    U_CP_SUM   = 4'd10,
    U_CP_CMP   = 4'd11,
    U_CP_LEFT  = 4'd12,
    U_CP_WRITE = 4'd13
  } upc_t;

  // Table address source.
  typedef enum logic [2:0] {
    A_CLR   = 3'd0,
    A_REQ   = 3'd1,
    A_CELL  = 3'd2,
    A_LEFT  = 3'd3,
    A_RIGHT = 3'd4
  } addr_sel_t;

  // Table write source.
  typedef enum logic [1:0] {
    W_NONE  = 2'd0,
    W_NEG   = 2'd1,
    W_OFFER = 2'd2,
    W_BEST  = 2'd3
  } wr_sel_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    J_ALWAYS     = 3'd0,
    J_CLR_LAST   = 3'd1,
    J_DISPATCH   = 3'd2,
    J_SPAN_BAD   = 3'd3,
    J_OUT_FREE   = 3'd4,
    J_SHORT      = 3'd5,
    J_LAST_SPLIT = 3'd6,
    J_CP_DONE    = 3'd7
  } jump_t;

  // One control word.
  typedef struct packed {
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      clr_inc;
    logic      ld_best;
    logic      ld_a;
    logic      ld_sum;
    logic      upd_best;
    logic      j_init;
    logic      j_inc;
    logic      cp_init;
    logic      cp_adv;
    logic      out_load;
    jump_t     jump;
    upc_t      tgt_true;
    upc_t      tgt_false;
  } ucode_t;

  // Saturating sum; minus infinity absorbs, finite sums never reach it.
  function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] t;
    logic signed [31:0] r;
    t = $signed({a[31], a}) + $signed({b[31], b});
    if ((a == NEG_INF) || (b == NEG_INF)) begin
      r = NEG_INF;
    end else if (t > $signed({POS_MAX[31], POS_MAX})) begin
      r = POS_MAX;
    end else if (t < $signed({NEG_MAX[31], NEG_MAX})) begin
      r = NEG_MAX;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  // Control store: the program for clear, offer, read and compute.
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t uc;
    uc = '0;
    uc.addr_sel  = A_REQ;
    uc.wr_sel    = W_NONE;
    uc.jump      = J_ALWAYS;
    uc.tgt_true  = U_IDLE;
    uc.tgt_false = U_IDLE;
    case (pc)
      U_CLR: begin
        uc.addr_sel  = A_CLR;
        uc.wr_sel    = W_NEG;
        uc.clr_inc   = 1'b1;
        uc.jump      = J_CLR_LAST;
        uc.tgt_true  = U_IDLE;
        uc.tgt_false = U_CLR;
      end
      U_IDLE: begin
        uc.jump = J_DISPATCH;
      end
      U_OF_RD: begin
        uc.jump      = J_SPAN_BAD;
        uc.tgt_true  = U_IDLE;
        uc.tgt_false = U_OF_WR;
      end
      U_OF_WR: begin
        uc.wr_sel   = W_OFFER;
        uc.tgt_true = U_IDLE;
      end
      U_RD_RD: begin
        uc.tgt_true = U_RD_OUT;
      end
      U_RD_OUT: begin
        uc.out_load  = 1'b1;
        uc.jump      = J_OUT_FREE;
        uc.tgt_true  = U_IDLE;
        uc.tgt_false = U_RD_OUT;
      end
      U_CP_INIT: begin
        uc.cp_init   = 1'b1;
        uc.jump      = J_SHORT;
        uc.tgt_true  = U_IDLE;
        uc.tgt_false = U_CP_CELL;
      end
      U_CP_CELL: begin
        uc.addr_sel = A_CELL;
        uc.j_init   = 1'b1;
        uc.tgt_true = U_CP_LEFT0;
      end
      U_CP_LEFT0: begin
        uc.addr_sel = A_LEFT;
        uc.ld_best  = 1'b1;
        uc.tgt_true = U_CP_RIGHT;
      end
      U_CP_RIGHT: begin
        uc.addr_sel = A_RIGHT;
        uc.ld_a     = 1'b1;
        uc.tgt_true = U_CP_SUM;
      end
      U_CP_SUM: begin
        uc.ld_sum   = 1'b1;
        uc.tgt_true = U_CP_CMP;
      end
      U_CP_CMP: begin
        uc.upd_best  = 1'b1;
        uc.j_inc     = 1'b1;
        uc.jump      = J_LAST_SPLIT;
        uc.tgt_true  = U_CP_WRITE;
        uc.tgt_false = U_CP_LEFT;
      end
      U_CP_LEFT: begin
        uc.addr_sel = A_LEFT;
        uc.tgt_true = U_CP_RIGHT;
      end
      U_CP_WRITE: begin
        uc.addr_sel  = A_CELL;
        uc.wr_sel    = W_BEST;
        uc.cp_adv    = 1'b1;
        uc.jump      = J_CP_DONE;
        uc.tgt_true  = U_IDLE;
        uc.tgt_false = U_CP_CELL;
      end
      default: begin
        uc.tgt_true = U_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

FILE: design/sfct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/span_future_cost_table.sv
// Top level: span score table with a microcoded clear, offer, read and compute sequencer.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | in_valid/in_stall  | in_item (sfct_pkg::in_item_t)
//  out     | output    | out_valid/out_stall| out_item (sfct_pkg::out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data (sentence_length)
//
//  An offer or a read is a registered RAM read, then a write or output step (a
//  bad-span offer skips the write). A clear writes one entry per cycle over all
//  DEPTH entries, DEPTH being (MAX_WORDS rounded up to a power of two) squared.
//  A compute steps through every split point of every span, reading the two
//  halves of each split in turn, since both reads share one RAM port.
//  Reset runs the same clearing pass with in_stall high; out_stall holds a read.
//
module span_future_cost_table #(
  parameter int MAX_WORDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfct_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sfct_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);

  import sfct_pkg::*;

  localparam int IW    = $clog2(MAX_WORDS);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_WORDS + 1);
  localparam int LW    = (NW > 6) ? NW : 6;
  localparam int EW    = LW + 1;
  localparam int XW    = (IW > 5) ? IW : 5;

  // Sequencer and datapath registers.
  upc_t               pc;
  upc_t               pc_next;
  ucode_t             uc;
  logic [AW-1:0]      clr_cnt;
  logic [5:0]         sentence_length;
  in_item_t           req;
  logic [IW-1:0]      s_cnt;
  logic [NW-1:0]      len_cnt;
  logic [IW-1:0]      j;
  logic signed [31:0] best;
  logic signed [31:0] a_reg;
  logic signed [31:0] sum_reg;

  // Table RAM signals.
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;
  logic signed [31:0] rd_score;

  // Derived values.
  logic               in_xfer;
  logic               out_free;
  logic [LW-1:0]      max_x;
  logic [LW-1:0]      len_x;
  logic [LW-1:0]      n_eff_x;
  logic [NW-1:0]      n_eff;
  logic [EW-1:0]      e_full;
  logic [IW-1:0]      e_idx;
  logic [IW-1:0]      j_inc1;
  logic [XW-1:0]      req_s_x;
  logic [XW-1:0]      req_e_x;
  logic [IW-1:0]      req_s;
  logic [IW-1:0]      req_e;
  logic               span_bad;
  logic               last_cell;
  logic               cp_done;
  logic               short_len;
  logic               last_split;
  logic               clr_last;
  logic signed [31:0] read_score;

  assign uc        = ucode_rom(pc);
  assign rd_score  = $signed(ram_rdata);
  assign in_stall  = (pc != U_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Effective sentence length, saturated to the table size.
  assign max_x   = LW'(MAX_WORDS);
  assign len_x   = LW'(sentence_length);
  assign n_eff_x = (len_x > max_x) ? max_x : len_x;
  assign n_eff   = n_eff_x[NW-1:0];

  // Span being computed and split point arithmetic.
  assign e_full     = EW'(s_cnt) + EW'(len_cnt) - EW'(1);
  assign e_idx      = e_full[IW-1:0];
  assign j_inc1     = IW'(j + 1'b1);
  assign last_cell  = (e_full == (EW'(n_eff) - EW'(1)));
  assign cp_done    = last_cell && (len_cnt == n_eff);
  assign short_len  = (n_eff < NW'(2));
  assign last_split = (j_inc1 == e_idx);
  assign clr_last   = (clr_cnt == {AW{1'b1}});

  // Span of the held request.
  assign req_s_x  = XW'(req.span_start);
  assign req_e_x  = XW'(req.span_end);
  assign req_s    = req_s_x[IW-1:0];
  assign req_e    = req_e_x[IW-1:0];
  assign span_bad = (req.span_start > req.span_end) || (LW'(req.span_end) >= max_x);
  assign read_score = span_bad ? NEG_INF : rd_score;

  // Next step of the sequencer.
  always_comb begin
    pc_next = pc;
    case (uc.jump)
      J_ALWAYS:     pc_next = uc.tgt_true;
      J_CLR_LAST:   pc_next = clr_last ? uc.tgt_true : uc.tgt_false;
      J_SPAN_BAD:   pc_next = span_bad ? uc.tgt_true : uc.tgt_false;
      J_OUT_FREE:   pc_next = out_free ? uc.tgt_true : uc.tgt_false;
      J_SHORT:      pc_next = short_len ? uc.tgt_true : uc.tgt_false;
      J_LAST_SPLIT: pc_next = last_split ? uc.tgt_true : uc.tgt_false;
      J_CP_DONE:    pc_next = cp_done ? uc.tgt_true : uc.tgt_false;
      J_DISPATCH: begin
        if (in_xfer) begin
          case (in_item.req_type)
            REQ_CLEAR:   pc_next = U_CLR;
            REQ_OFFER:   pc_next = U_OF_RD;
            REQ_COMPUTE: pc_next = U_CP_INIT;
            REQ_READ:    pc_next = U_RD_RD;
            default:     pc_next = U_IDLE;
          endcase
        end else begin
          pc_next = U_IDLE;
        end
      end
      default: pc_next = U_IDLE;
    endcase
  end

  // Table address and write control from the control word.
  always_comb begin
    case (uc.addr_sel)
      A_CLR:   ram_addr = clr_cnt;
      A_REQ:   ram_addr = {req_s, req_e};
      A_CELL:  ram_addr = {s_cnt, e_idx};
      A_LEFT:  ram_addr = {s_cnt, j};
      A_RIGHT: ram_addr = {j_inc1, e_idx};
      default: ram_addr = {req_s, req_e};
    endcase
    case (uc.wr_sel)
      W_NEG: begin
        ram_we    = 1'b1;
        ram_wdata = NEG_INF;
      end
      W_OFFER: begin
        ram_we    = (req.offer_score > rd_score);
        ram_wdata = req.offer_score;
      end
      W_BEST: begin
        ram_we    = 1'b1;
        ram_wdata = best;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = best;
      end
    endcase
  end

  sfct_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= U_CLR;
      clr_cnt         <= '0;
      sentence_length <= 6'd1;
      out_valid       <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uc.clr_inc) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sentence_length <= cfg_data;
      end
      if (uc.out_load && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Compute loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_cnt   <= '0;
      len_cnt <= '0;
      j       <= '0;
    end else begin
      if (uc.cp_init) begin
        s_cnt   <= '0;
        len_cnt <= NW'(2);
      end else if (uc.cp_adv) begin
        if (last_cell) begin
          s_cnt   <= '0;
          len_cnt <= len_cnt + 1'b1;
        end else begin
          s_cnt <= s_cnt + 1'b1;
        end
      end
      if (uc.j_init) begin
        j <= s_cnt;
      end else if (uc.j_inc) begin
        j <= j_inc1;
      end
    end
  end

  // Payload registers: held request, running best, sum and output item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req <= in_item;
    end
    if (uc.ld_best) begin
      best <= rd_score;
    end else if (uc.upd_best && (sum_reg > best)) begin
      best <= sum_reg;
    end
    if (uc.ld_a) begin
      a_reg <= rd_score;
    end
    if (uc.ld_sum) begin
      sum_reg <= sat_sum(a_reg, rd_score);
    end
    if (uc.out_load && out_free) begin
      out_item.span_score   <= read_score;
      out_item.span_covered <= (read_score != NEG_INF);
    end
  end

  // A result appears only from the read output step.
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == U_RD_OUT))
    else $error("result raised outside the read output step");

  // The table is never written while waiting for a request.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (pc == U_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // The split point stays strictly inside the span being computed.
  a_split_in_span: assert property (@(posedge clk) disable iff (rst)
    (pc == U_CP_RIGHT) |-> (j < e_idx))
    else $error("split point outside span");

  // The covered flag agrees with the delivered score.
  a_covered_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.span_covered == (out_item.span_score != NEG_INF)))
    else $error("covered flag disagrees with score");

  // Every reset starts the clearing pass from the first entry.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> ((pc == U_CLR) && (clr_cnt == '0)))
    else $error("clearing pass not started after reset");

endmodule

FILE: sim/span_cost_monitor.sv
// Channel monitor for the span score table: tracks the table and checks every read result.
`timescale 1ns / 1ps
module span_cost_monitor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sfct_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sfct_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  reads_done,
  output int                  fills_done,
  output int                  clears_done
);

  import sfct_pkg::*;

  localparam int MAX_WORDS = 32;

  // Own copy of the table and of the sentence length register.
  logic signed [31:0] cost_tab [0:MAX_WORDS-1][0:MAX_WORDS-1];
  logic [5:0]         words;

  // Read results still owed by the block, oldest first.
  out_item_t owed_reads[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    reads_done  = 0;
    fills_done  = 0;
    clears_done = 0;
    words       = 6'd1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("monitor: %s mismatch at %0t: got %h, want %h", what, $time, got, want);
    fail_count++;
  endtask

  task automatic wipe_table();
    for (int s = 0; s < MAX_WORDS; s++) begin
      for (int e = 0; e < MAX_WORDS; e++) begin
        cost_tab[s][e] = NEG_INF;
      end
    end
  endtask

  // Sum of two span scores: minus infinity absorbs, finite sums clamp to the finite range.
  function automatic logic signed [31:0] join_cost(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    longint t;
    if ((a == NEG_INF) || (b == NEG_INF)) begin
      return NEG_INF;
    end
    t = longint'(a) + longint'(b);
    if (t > longint'(POS_MAX)) begin
      t = longint'(POS_MAX);
    end
    if (t < longint'(NEG_MAX)) begin
      t = longint'(NEG_MAX);
    end
    return t[31:0];
  endfunction

  // Interval fill over the sentence, shortest spans first.
  task automatic fill_spans();
    int n;
    int e;
    logic signed [31:0] joined;
    n = (words > MAX_WORDS) ? MAX_WORDS : int'(words);
    for (int len = 2; len <= n; len++) begin
      for (int s = 0; s + len <= n; s++) begin
        e = s + len - 1;
        for (int j = s; j < e; j++) begin
          joined = join_cost(cost_tab[s][j], cost_tab[j + 1][e]);
          if (joined > cost_tab[s][e]) begin
            cost_tab[s][e] = joined;
          end
        end
      end
    end
  endtask

  // Everything is sampled at the rising edge, where transfers happen.
  always @(posedge clk) begin : watch
    in_item_t           req;
    out_item_t          want;
    logic signed [31:0] offered;
    logic               span_ok;
    if (rst) begin
      wipe_table();
      words = 6'd1;
      owed_reads.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        words = cfg_data;
      end
      // Result side: compare with the oldest owed read.
      if (out_valid && !out_stall) begin
        if (owed_reads.size() == 0) begin
          report_mismatch("unexpected result", out_item.span_score,
                          {31'd0, out_item.span_covered});
        end else begin
          want = owed_reads.pop_front();
          if (out_item.span_score !== want.span_score) begin
            report_mismatch("span_score", out_item.span_score, want.span_score);
          end
          if (out_item.span_covered !== want.span_covered) begin
            report_mismatch("span_covered", {31'd0, out_item.span_covered},
                            {31'd0, want.span_covered});
          end
          reads_done++;
        end
      end
      // Request side: update the table or record the owed read.
      if (in_valid && !in_stall) begin
        req     = in_item;
        offered = req.offer_score;
        span_ok = (req.span_start <= req.span_end) && (int'(req.span_end) < MAX_WORDS);
        case (req.req_type)
          REQ_CLEAR: begin
            wipe_table();
            clears_done++;
          end
          REQ_OFFER: begin
            if (span_ok && (offered > cost_tab[req.span_start][req.span_end])) begin
              cost_tab[req.span_start][req.span_end] = offered;
            end
          end
          REQ_COMPUTE: begin
            fill_spans();
            fills_done++;
          end
          REQ_READ: begin
            want.span_score   = span_ok ? cost_tab[req.span_start][req.span_end] : NEG_INF;
            want.span_covered = (want.span_score != NEG_INF);
            owed_reads.push_back(want);
          end
          default: begin
          end
        endcase
      end
    end
    pending = owed_reads.size();
  end

endmodule

FILE: sim/tb_span_future_cost_table.sv
// Testbench top for the span score table: stimulus, result drain and verdict.
`timescale 1ns / 1ps
module tb_span_future_cost_table;
  import sfct_pkg::*;

  localparam int TARGET_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int LIMIT         = 3000000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;

  int fail_count;
  int pending;
  int reads_done;
  int fills_done;
  int clears_done;
  int cycle_count;
  int sent;
  int settings_done;
  bit quick;

  span_future_cost_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  span_cost_monitor cost_watch (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .reads_done  (reads_done),
    .fills_done  (fills_done),
    .clears_done (clears_done)
  );

  // Clock and cycle count.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog on the whole run.
  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("tb: timeout after %0d cycles, %0d reads still owed", cycle_count, pending);
    $display("tb: failure");
    $finish;
  end

  // Random score: mostly modest negative costs, with the extreme codes mixed in.
  function automatic logic signed [31:0] pick_score();
    int r;
    logic signed [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return NEG_INF;
    end
    if (r < 13) begin
      return POS_MAX;
    end
    if (r < 18) begin
      return NEG_MAX;
    end
    if (r < 45) begin
      return $urandom;
    end
    v = $urandom_range(0, 32'h003F_FFFF);
    v = v - 32'sh0030_0000;
    return v;
  endfunction

  // One request transfer, after a random gap unless the phase runs back to back.
  task automatic send_req(input req_type_t r, input int s, input int e,
                          input logic signed [31:0] v);
    int gap;
    in_item_t it;
    it.req_type    = r;
    it.span_start  = s[4:0];
    it.span_end    = e[4:0];
    it.offer_score = v;
    gap = quick ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // A well-formed span inside the sentence; any ordered span when the sentence is empty.
  task automatic send_in_sentence(input req_type_t r, input int n);
    int s;
    int e;
    if (n == 0) begin
      s = $urandom_range(0, 31);
      e = $urandom_range(s, 31);
    end else begin
      s = $urandom_range(0, n - 1);
      e = $urandom_range(s, n - 1);
    end
    send_req(r, s, e, pick_score());
    sent++;
  endtask

  // Noise: any span, reversed ones included, offered or read.
  task automatic send_noise();
    req_type_t r;
    r = ($urandom_range(0, 1) == 0) ? REQ_OFFER : REQ_READ;
    send_req(r, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    sent++;
  endtask

  // Drop valid and wait until every owed read has come back and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the sentence length register.
  task automatic write_words(input logic [5:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Result drain: random stall per result, eager stretches, and one long hold-off.
  initial begin : drain
    int gap;
    int taken;
    bit eager;
    out_stall = 1'b0;
    taken     = 0;
    eager     = 1'b0;
    @(negedge clk);
    forever begin
      if ((taken % 32) == 0) begin
        eager = ($urandom_range(0, 2) == 0);
      end
      gap = eager ? 0 : $urandom_range(0, 9);
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus: directed corner cases, then random sentences.
  initial begin : stimulus
    int r;
    int len;
    int n_eff;
    int rounds;
    int count;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 6'd0;
    sent          = 0;
    settings_done = 0;
    quick         = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // The block clears its table after reset; wait for it to take requests.
    while (in_stall) @(negedge clk);

    // Saturation both ways, minus infinity absorbing, bad and outlying spans.
    write_words(6'd5);
    send_req(REQ_READ, 0, 0, 32'sd0);
    send_req(REQ_OFFER, 0, 0, POS_MAX);
    send_req(REQ_OFFER, 1, 1, POS_MAX);
    send_req(REQ_OFFER, 2, 2, NEG_MAX);
    send_req(REQ_OFFER, 3, 3, NEG_MAX);
    send_req(REQ_OFFER, 0, 3, NEG_INF);
    send_req(REQ_OFFER, 3, 1, 32'sd1000);
    send_req(REQ_OFFER, 10, 20, 32'sd12345);
    send_req(REQ_OFFER, 5, 5, 32'sd100);
    send_req(REQ_OFFER, 5, 5, 32'sd50);
    send_req(REQ_OFFER, 0, 31, -32'sd5);
    send_req(REQ_COMPUTE, 0, 0, 32'sd0);
    send_req(REQ_READ, 0, 1, 32'sd0);
    send_req(REQ_READ, 2, 3, 32'sd0);
    send_req(REQ_READ, 1, 2, 32'sd0);
    send_req(REQ_READ, 0, 3, 32'sd0);
    send_req(REQ_READ, 3, 4, 32'sd0);
    send_req(REQ_READ, 3, 1, 32'sd0);
    send_req(REQ_READ, 10, 20, 32'sd0);
    send_req(REQ_READ, 5, 5, 32'sd0);
    send_req(REQ_READ, 0, 31, 32'sd0);
    // With an empty sentence a compute leaves the table alone.
    settle();
    write_words(6'd0);
    send_req(REQ_OFFER, 0, 2, 32'sd7);
    send_req(REQ_COMPUTE, 0, 0, 32'sd0);
    send_req(REQ_READ, 0, 4, 32'sd0);
    // A length above the table size fills the whole triangle, then the table is cleared.
    settle();
    write_words(6'd63);
    send_req(REQ_COMPUTE, 0, 0, 32'sd0);
    send_req(REQ_READ, 0, 31, 32'sd0);
    send_req(REQ_CLEAR, 0, 0, 32'sd0);
    send_req(REQ_READ, 0, 1, 32'sd0);
    sent += 28;

    // Random sentences: mostly set length, clear, offers, fill, reads.
    while (sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        len = $urandom_range(33, 63);
      end else if (r < 6) begin
        len = 32;
      end else if (r < 9) begin
        len = 0;
      end else if (r < 25) begin
        len = $urandom_range(9, 16);
      end else begin
        len = $urandom_range(1, 8);
      end
      settle();
      write_words(len[5:0]);
      n_eff = (len > 32) ? 32 : len;
      quick = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        send_req(REQ_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        sent++;
      end
      rounds = (n_eff > 16) ? 1 : $urandom_range(1, 3);
      repeat (rounds) begin
        count = $urandom_range(4, 25);
        repeat (count) begin
          if ($urandom_range(0, 9) == 0) begin
            send_noise();
          end else begin
            send_in_sentence(REQ_OFFER, n_eff);
          end
        end
        send_req(REQ_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        sent++;
        count = $urandom_range(3, 15);
        repeat (count) begin
          if ($urandom_range(0, 9) == 0) begin
            send_noise();
          end else begin
            send_in_sentence(REQ_READ, n_eff);
          end
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        send_req(REQ_CLEAR, 0, 0, 32'sd0);
        sent++;
      end
      // A closing read marks the end of the phase for the settle step.
      send_in_sentence(REQ_READ, n_eff);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb: %0d requests over %0d length settings in %0d cycles", sent, settings_done,
             cycle_count);
    $display("tb: %0d reads checked, %0d table fills, %0d clears, %0d mismatches",
             reads_done, fills_done, clears_done, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
